@@ rtl/core/pol_pkg.sv @@
// -----------------------------------------------------------------------------
// pol_pkg - shared definitions for the positional ordered list
// Sizes, field codes and the control word broadcast to the cell row.
// -----------------------------------------------------------------------------
package pol_pkg;

    // list capacity and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = 8;
    localparam int VAL_W = 32;

    // operation codes on the input word
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;

    // status codes on the result word
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [IDX_W-1:0]         idx;   // insert or delete position
        logic [IDX_W-1:0]         tail;  // last occupied cell for rotation
        logic signed [VAL_W-1:0]  value; // value to insert
    } cell_ctrl_t;

endpackage

@@ rtl/core/pol_cell.sv @@
// -----------------------------------------------------------------------------
// pol_cell - one storage cell of the list row
// Holds one element and takes it from its left or right neighbour, the
// inserted value or the head cell, as the broadcast control word says.
// -----------------------------------------------------------------------------
module pol_cell (
    input  logic                               aclk,
    input  logic [pol_pkg::IDX_W-1:0]          cell_index,
    input  pol_pkg::cell_ctrl_t                ctrl,
    input  logic signed [pol_pkg::VAL_W-1:0]   left_data,
    input  logic signed [pol_pkg::VAL_W-1:0]   right_data,
    input  logic signed [pol_pkg::VAL_W-1:0]   head_data,
    output logic signed [pol_pkg::VAL_W-1:0]   data
);

    logic signed [pol_pkg::VAL_W-1:0] data_reg;
    logic signed [pol_pkg::VAL_W-1:0] data_next;

    // pick the new content of this cell
    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            pol_pkg::CELL_INSERT: begin
                if (cell_index == ctrl.idx) begin
                    data_next = ctrl.value;
                end else if (cell_index > ctrl.idx) begin
                    data_next = left_data;
                end
            end
            pol_pkg::CELL_DELETE: begin
                if (cell_index >= ctrl.idx) begin
                    data_next = right_data;
                end
            end
            pol_pkg::CELL_ROTATE: begin
                if (cell_index == ctrl.tail) begin
                    data_next = head_data;
                end else begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    // hold the element
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/core/positional_ordered_list_unit.sv @@
// -----------------------------------------------------------------------------
// positional_ordered_list_unit - ordered list with positional insert/delete
// A row of cells keeps the list in order; insert and delete shift the row,
// a dump rotates the row through the head cell once.
// -----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)                | tlast
//  s_      | in  | mode[1:0] position[9:2] value[41:10]         | -
//  m_      | out | status[1:0] element[33:2] length[38:34]      | last
//
// Insert, delete and unknown modes give one word each.
// A dump gives one word per element, one a cycle unless stalled, set by the
// rotation of the cell row through cell 0; an empty dump gives one word.
// A new input word is taken only between operations while the output
// register is free or being drained. Reset clears the count, the control
// state and the output valid; cell contents stay undefined until written.
// A stalled output holds the rotation in place.
// -----------------------------------------------------------------------------
module positional_ordered_list_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[1:0], position[9:2], value[41:10], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], element[33:2], length[38:34], zero
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    localparam int IDX_W = pol_pkg::IDX_W;
    localparam int CNT_W = pol_pkg::CNT_W;
    localparam int POS_W = pol_pkg::POS_W;
    localparam int VAL_W = pol_pkg::VAL_W;

    state_t                   state_reg,  state_next;
    logic [CNT_W-1:0]         count_reg,  count_next;
    logic [CNT_W-1:0]         dump_reg,   dump_next;
    logic                     valid_reg,  valid_next;
    logic [1:0]               status_reg, status_next;
    logic signed [VAL_W-1:0]  elem_reg,   elem_next;
    logic [CNT_W-1:0]         len_reg,    len_next;
    logic                     last_reg,   last_next;

    pol_pkg::cell_ctrl_t      ctrl;
    logic signed [VAL_W-1:0]  cell_data [pol_pkg::DEPTH];

    logic [1:0]               in_mode;
    logic [POS_W-1:0]         in_pos;
    logic signed [VAL_W-1:0]  in_value;
    logic [POS_W-1:0]         pos_m1;
    logic [POS_W-1:0]         count_pos;
    logic [IDX_W-1:0]         ins_idx;
    logic [IDX_W-1:0]         del_idx;
    logic [IDX_W-1:0]         tail_idx;
    logic                     out_free;
    logic                     in_accept;
    logic                     dump_last;

    // unpack the input word
    assign in_mode  = s_tdata[1:0];
    assign in_pos   = s_tdata[9:2];
    assign in_value = s_tdata[41:10];

    assign out_free  = !valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    // resolve list positions to cell indexes
    assign pos_m1    = in_pos - POS_W'(1);
    assign count_pos = POS_W'(count_reg);
    assign tail_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign dump_last = (dump_reg == count_reg - CNT_W'(1));

    always_comb begin
        if (in_pos <= POS_W'(1)) begin
            ins_idx = '0;
        end else if (in_pos > count_pos) begin
            ins_idx = count_reg[IDX_W-1:0];
        end else begin
            ins_idx = IDX_W'(pos_m1);
        end
        if (in_pos <= POS_W'(1)) begin
            del_idx = '0;
        end else if (in_pos >= count_pos) begin
            del_idx = tail_idx;
        end else begin
            del_idx = IDX_W'(pos_m1);
        end
    end

    // sequence operations and load the output register
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        dump_next   = dump_reg;
        valid_next  = valid_reg && !m_tready;
        status_next = status_reg;
        elem_next   = elem_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        ctrl.op     = pol_pkg::CELL_HOLD;
        ctrl.idx    = ins_idx;
        ctrl.tail   = tail_idx;
        ctrl.value  = in_value;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    valid_next  = 1'b1;
                    status_next = pol_pkg::ST_OK;
                    elem_next   = '0;
                    len_next    = count_reg;
                    last_next   = 1'b1;
                    case (in_mode)
                        pol_pkg::MODE_INSERT: begin
                            if (count_reg == CNT_W'(pol_pkg::DEPTH)) begin
                                status_next = pol_pkg::ST_FULL;
                            end else begin
                                ctrl.op    = pol_pkg::CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                len_next   = count_next;
                            end
                        end
                        pol_pkg::MODE_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = pol_pkg::ST_EMPTY;
                            end else begin
                                ctrl.op    = pol_pkg::CELL_DELETE;
                                ctrl.idx   = del_idx;
                                count_next = count_reg - CNT_W'(1);
                                len_next   = count_next;
                            end
                        end
                        pol_pkg::MODE_DUMP: begin
                            if (count_reg == '0) begin
                                status_next = pol_pkg::ST_EMPTY;
                            end else begin
                                valid_next = 1'b0;
                                state_next = S_DUMP;
                                dump_next  = '0;
                            end
                        end
                        default: begin
                            status_next = pol_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    ctrl.op     = pol_pkg::CELL_ROTATE;
                    valid_next  = 1'b1;
                    status_next = pol_pkg::ST_OK;
                    elem_next   = cell_data[0];
                    len_next    = count_reg;
                    last_next   = dump_last;
                    dump_next   = dump_reg + CNT_W'(1);
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dump_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            dump_reg  <= dump_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        elem_reg   <= elem_next;
        len_reg    <= len_next;
        last_reg   <= last_next;
    end

    // row of cells
    for (genvar i = 0; i < pol_pkg::DEPTH; i++) begin : g_cell
        logic signed [VAL_W-1:0] left_d;
        logic signed [VAL_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == pol_pkg::DEPTH - 1) begin : g_lastc
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        pol_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(i)),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, len_reg, elem_reg, status_reg};

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(pol_pkg::DEPTH))
        else $error("list count beyond capacity");

    a_dump_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> (count_reg != '0))
        else $error("dump running on an empty list");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == S_IDLE))
        else $error("input taken during a dump");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_mode == pol_pkg::MODE_INSERT
         && count_reg != CNT_W'(pol_pkg::DEPTH))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_dump_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> (dump_reg < count_reg))
        else $error("dump index past list end");

endmodule
